// ----- hdl/nsc_pkg.sv -----
// Package for the NMEA sentence checker: character codes, result codes,
// the result struct and the hex digit decoder. No dependencies.
package nsc_pkg;

    localparam int MAX_LEN_DEFAULT = 128;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 7;
    localparam int LEN_MAX         = 127;
    localparam int COMMA_MAX       = 9;
    localparam int KIND_POS        = 6;   // kept bytes needed to cover offsets 3..5

    localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_RMC   = 2'd1,
        KIND_GGA   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_SUM_ERR   = 2'd1,
        STAT_PARSE_ERR = 2'd2
    } status_t;

    typedef struct packed {
        kind_t             kind;
        status_t           status;
        logic [BYTE_W-1:0] computed_sum;
        logic [BYTE_W-1:0] received_sum;
        logic [LEN_W-1:0]  stored_length;
    } result_t;

    // Expected type characters at offsets 3, 4, 5 (index 0..2).
    function automatic logic [BYTE_W-1:0] rmc_char(input logic [1:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            2'd0:    ch = 8'h52;  // R
            2'd1:    ch = 8'h4D;  // M
            default: ch = 8'h43;  // C
        endcase
        return ch;
    endfunction

    function automatic logic [BYTE_W-1:0] gga_char(input logic [1:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            2'd0:    ch = 8'h47;  // G
            2'd1:    ch = 8'h47;  // G
            default: ch = 8'h41;  // A
        endcase
        return ch;
    endfunction

    // ASCII hex digit to nibble; anything else reads as zero.
    function automatic logic [3:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = c[3:0];
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            v = 4'(c[3:0] + 4'd9);
        else
            v = 4'd0;
        return v;
    endfunction

endpackage

// ----- hdl/nmea_sentence_checker.sv -----
// Top level of the NMEA 0183 sentence checker: input byte register, tracking
// state and result register. Depends on nsc_pkg and nsc_sentence_state.
//
// Usage:
//   s_* channel takes one received UART byte per request (s_tdata[7:0]).
//   A '$' restarts a sentence; a '\n' closes it and yields one result
//   request on m_*; every other byte yields nothing.
//   m_tuser carries the sentence kind (0 other, 1 RMC, 2 GGA); m_tdata
//   carries status, computed XOR, received hex sum and kept length.
// Order: an accepted byte is held in the input register, then folded into
//   the sentence state; a newline's result is registered in the same cycle
//   as that fold, which waits for a free result slot.
// Throughput: one byte per clock, except that a newline waits while the result slot is full.
// Reset: all sentence state clears (type flags set), both valid flags drop.
// Stall: while a result waits on m_tready, ordinary bytes keep flowing; a
//   following newline waits in the input register until the result slot
//   frees, and s_tready is low only while it waits.
module nmea_sentence_checker #(
    parameter int MAX_LEN = nsc_pkg::MAX_LEN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [1:0] check_status, [9:2] computed_sum,
                                   // [17:10] received_sum, [24:18] stored_length,
                                   // [31:25] zero
    output logic [1:0]  m_tuser    // [1:0] sentence_kind
);

    logic                        in_valid_reg, in_valid_next;
    logic [nsc_pkg::BYTE_W-1:0]  in_byte_reg, in_byte_next;
    logic                        out_valid_reg, out_valid_next;
    nsc_pkg::result_t            out_res_reg, out_res_next;
    nsc_pkg::result_t            step_res;
    logic                        in_is_nl;
    logic                        advance;
    logic                        s_fire;

    assign in_is_nl = (in_byte_reg == nsc_pkg::CH_NEWLINE);
    // ordinary bytes always move on; a newline needs a free result slot
    assign advance  = in_valid_reg && (!in_is_nl || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    nsc_sentence_state #(
        .MAX_LEN (MAX_LEN)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .step_byte (in_byte_reg),
        .result    (step_res)
    );

    always_comb
    begin
        in_valid_next  = s_fire || (in_valid_reg && !advance);
        in_byte_next   = s_fire ? s_tdata : in_byte_reg;
        out_valid_next = (out_valid_reg && !m_tready) || (advance && in_is_nl);
        out_res_next   = (advance && in_is_nl) ? step_res : out_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {7'd0, out_res_reg.stored_length, out_res_reg.received_sum,
                       out_res_reg.computed_sum, out_res_reg.status};

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> in_valid_reg)
        else $error("accepted byte not held in input register");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_is_nl))
        else $error("result raised without a newline");

    a_nl_waits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_is_nl && out_valid_reg && !m_tready |=> in_valid_reg && in_is_nl)
        else $error("newline dropped while result slot busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> $stable(out_res_reg))
        else $error("pending result overwritten");

endmodule

// ----- hdl/nsc_sentence_state.sv -----
// Per-sentence tracking state of the NMEA checker: checksum, hex digits,
// type match, comma tally. Depends on nsc_pkg.
module nsc_sentence_state #(
    parameter int MAX_LEN = nsc_pkg::MAX_LEN_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_en,
    input  logic [nsc_pkg::BYTE_W-1:0]   step_byte,
    output nsc_pkg::result_t             result
);

    localparam int CNT_W = $clog2(MAX_LEN);
    localparam int WIDE_W = CNT_W + nsc_pkg::LEN_W;

    logic [CNT_W-1:0] kept_count_reg, kept_count_next;
    logic [7:0]       running_xor_reg, running_xor_next;
    logic             star_found_reg, star_found_next;
    logic [1:0]       digits_reg, digits_next;
    logic [7:0]       hex_value_reg, hex_value_next;
    logic [1:0]       type_flags_reg, type_flags_next;
    logic [3:0]       comma_tally_reg, comma_tally_next;
    logic             text_ended_reg, text_ended_next;
    logic             lead_dollar_reg, lead_dollar_next;

    // working copies: start of sentence, then after keeping the byte
    logic [CNT_W-1:0] cnt_w;
    logic [7:0]       xor_w;
    logic             star_w;
    logic [1:0]       dig_w;
    logic [7:0]       hex_w;
    logic [1:0]       flags_w;
    logic [3:0]       comma_w;
    logic             ended_w;
    logic             lead_w;
    logic [CNT_W-1:0] pos;
    logic             restart;
    logic             is_nl;
    logic [1:0]       tidx;
    logic [WIDE_W-1:0] cnt_wide;
    nsc_pkg::kind_t   kind;

    assign restart = (step_byte == nsc_pkg::CH_DOLLAR);
    assign is_nl   = (step_byte == nsc_pkg::CH_NEWLINE);

    always_comb
    begin
        if (restart)
        begin
            cnt_w   = '0;
            xor_w   = '0;
            star_w  = 1'b0;
            dig_w   = '0;
            hex_w   = '0;
            flags_w = 2'b11;
            comma_w = '0;
            ended_w = 1'b0;
            lead_w  = 1'b0;
        end
        else
        begin
            cnt_w   = kept_count_reg;
            xor_w   = running_xor_reg;
            star_w  = star_found_reg;
            dig_w   = digits_reg;
            hex_w   = hex_value_reg;
            flags_w = type_flags_reg;
            comma_w = comma_tally_reg;
            ended_w = text_ended_reg;
            lead_w  = lead_dollar_reg;
        end
        pos  = cnt_w;
        tidx = 2'(pos - CNT_W'(3));

        if (pos < CNT_W'(MAX_LEN - 1))
        begin
            cnt_w = CNT_W'(pos + CNT_W'(1));
            if (!ended_w)
            begin
                if (step_byte == nsc_pkg::CH_NUL)
                begin
                    ended_w = 1'b1;
                    if (pos <= CNT_W'(5))
                        flags_w = 2'b00;
                end
                else
                begin
                    if (pos == '0 && restart)
                        lead_w = 1'b1;
                    if (pos >= CNT_W'(3) && pos <= CNT_W'(5))
                    begin
                        if (step_byte != nsc_pkg::rmc_char(tidx))
                            flags_w[0] = 1'b0;
                        if (step_byte != nsc_pkg::gga_char(tidx))
                            flags_w[1] = 1'b0;
                    end
                    if (step_byte == nsc_pkg::CH_COMMA && comma_w < 4'(nsc_pkg::COMMA_MAX))
                        comma_w = 4'(comma_w + 4'd1);
                    if (star_w)
                    begin
                        if (dig_w == 2'd0)
                        begin
                            hex_w = {nsc_pkg::hex_digit(step_byte), 4'd0};
                            dig_w = 2'd1;
                        end
                        else if (dig_w == 2'd1)
                        begin
                            hex_w = {hex_w[7:4], nsc_pkg::hex_digit(step_byte)};
                            dig_w = 2'd2;
                        end
                    end
                    else if (step_byte == nsc_pkg::CH_STAR)
                        star_w = 1'b1;
                    else if (pos >= CNT_W'(1))
                        xor_w = xor_w ^ step_byte;
                end
            end
        end
    end

    // result as seen after the current byte is kept
    always_comb
    begin
        cnt_wide = {{nsc_pkg::LEN_W{1'b0}}, cnt_w};
        kind     = nsc_pkg::KIND_OTHER;
        if (cnt_wide >= WIDE_W'(nsc_pkg::KIND_POS))
        begin
            if (flags_w[0])
                kind = nsc_pkg::KIND_RMC;
            else if (flags_w[1])
                kind = nsc_pkg::KIND_GGA;
        end
        result.kind          = kind;
        result.computed_sum  = xor_w;
        result.received_sum  = hex_w;
        result.stored_length = (cnt_wide > WIDE_W'(nsc_pkg::LEN_MAX)) ?
                               nsc_pkg::LEN_W'(nsc_pkg::LEN_MAX) : cnt_wide[nsc_pkg::LEN_W-1:0];
        if (!lead_w || !star_w)
            result.status = nsc_pkg::STAT_PARSE_ERR;
        else if (xor_w != hex_w)
            result.status = nsc_pkg::STAT_SUM_ERR;
        else if (comma_w == 4'd0)
            result.status = nsc_pkg::STAT_PARSE_ERR;
        else if (kind != nsc_pkg::KIND_OTHER && comma_w < 4'(nsc_pkg::COMMA_MAX))
            result.status = nsc_pkg::STAT_PARSE_ERR;
        else
            result.status = nsc_pkg::STAT_OK;
    end

    // newline ends the sentence: report, then clear
    always_comb
    begin
        kept_count_next  = kept_count_reg;
        running_xor_next = running_xor_reg;
        star_found_next  = star_found_reg;
        digits_next      = digits_reg;
        hex_value_next   = hex_value_reg;
        type_flags_next  = type_flags_reg;
        comma_tally_next = comma_tally_reg;
        text_ended_next  = text_ended_reg;
        lead_dollar_next = lead_dollar_reg;
        if (step_en)
        begin
            if (is_nl)
            begin
                kept_count_next  = '0;
                running_xor_next = '0;
                star_found_next  = 1'b0;
                digits_next      = '0;
                hex_value_next   = '0;
                type_flags_next  = 2'b11;
                comma_tally_next = '0;
                text_ended_next  = 1'b0;
                lead_dollar_next = 1'b0;
            end
            else
            begin
                kept_count_next  = cnt_w;
                running_xor_next = xor_w;
                star_found_next  = star_w;
                digits_next      = dig_w;
                hex_value_next   = hex_w;
                type_flags_next  = flags_w;
                comma_tally_next = comma_w;
                text_ended_next  = ended_w;
                lead_dollar_next = lead_w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count_reg  <= '0;
            running_xor_reg <= '0;
            star_found_reg  <= 1'b0;
            digits_reg      <= '0;
            hex_value_reg   <= '0;
            type_flags_reg  <= 2'b11;
            comma_tally_reg <= '0;
            text_ended_reg  <= 1'b0;
            lead_dollar_reg <= 1'b0;
        end
        else
        begin
            kept_count_reg  <= kept_count_next;
            running_xor_reg <= running_xor_next;
            star_found_reg  <= star_found_next;
            digits_reg      <= digits_next;
            hex_value_reg   <= hex_value_next;
            type_flags_reg  <= type_flags_next;
            comma_tally_reg <= comma_tally_next;
            text_ended_reg  <= text_ended_next;
            lead_dollar_reg <= lead_dollar_next;
        end
    end

    a_comma_sat: assert property (@(posedge clk) disable iff (!rst_n)
        comma_tally_reg <= 4'(nsc_pkg::COMMA_MAX))
        else $error("comma tally past saturation");

    a_digits_need_star: assert property (@(posedge clk) disable iff (!rst_n)
        digits_reg != 2'd0 |-> star_found_reg)
        else $error("hex digits counted without a star");

    a_nl_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && is_nl |=> kept_count_reg == '0 && !star_found_reg && type_flags_reg == 2'b11)
        else $error("state not cleared after newline");

endmodule

// ----- verif/nsc_stream_checker.sv -----
// Stream checker for the NMEA sentence checker: tracks every byte request on
// s_*, forms the expected sentence report and compares it with each m_* request.
// Depends on nsc_pkg.
module nsc_stream_checker #(
    parameter int MAX_LEN = nsc_pkg::MAX_LEN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatches,
    output int          reports_pending
);
    import nsc_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN);
    localparam logic [23:0] RMC_TAG = "RMC";
    localparam logic [23:0] GGA_TAG = "GGA";

    // sentence state
    logic [CNT_W-1:0] kept;
    logic [7:0]       xor_acc;
    logic             star_seen;
    logic [1:0]       digit_cnt;
    logic [7:0]       sum_field;
    logic [1:0]       type_flags;   // bit0 still RMC, bit1 still GGA
    logic [3:0]       commas;
    logic             nul_seen;
    logic             dollar_first;

    result_t sentence_reports[$];
    result_t want;

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
        if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
        return 4'h0;
    endfunction

    task automatic clear_sentence();
        kept         = '0;
        xor_acc      = '0;
        star_seen    = 1'b0;
        digit_cnt    = '0;
        sum_field    = '0;
        type_flags   = 2'b11;
        commas       = '0;
        nul_seen     = 1'b0;
        dollar_first = 1'b0;
    endtask

    // One kept byte; a NUL freezes everything but the kept count.
    task automatic absorb_byte(input logic [7:0] c);
        int pos;
        pos  = kept;
        kept = kept + 1'b1;
        if (nul_seen)
            return;
        if (c == CH_NUL)
        begin
            nul_seen = 1'b1;
            if (pos <= 5)
                type_flags = 2'b00;
            return;
        end
        if (pos == 0 && c == CH_DOLLAR)
            dollar_first = 1'b1;
        if (pos >= 3 && pos <= 5)
        begin
            if (c != RMC_TAG[8*(5-pos) +: 8])
                type_flags[0] = 1'b0;
            if (c != GGA_TAG[8*(5-pos) +: 8])
                type_flags[1] = 1'b0;
        end
        if (c == CH_COMMA && commas < COMMA_MAX)
            commas = commas + 1'b1;
        if (star_seen)
        begin
            if (digit_cnt == 2'd0)
            begin
                sum_field = {digit_value(c), 4'h0};
                digit_cnt = 2'd1;
            end
            else if (digit_cnt == 2'd1)
            begin
                sum_field[3:0] = digit_value(c);
                digit_cnt      = 2'd2;
            end
        end
        else if (c == CH_STAR)
            star_seen = 1'b1;
        else if (pos >= 1)
            xor_acc = xor_acc ^ c;
    endtask

    task automatic take_byte(input logic [7:0] c);
        result_t r;
        if (c == CH_DOLLAR)
            clear_sentence();
        if (kept < MAX_LEN - 1)
            absorb_byte(c);
        if (c == CH_NEWLINE)
        begin
            r.kind = KIND_OTHER;
            if (kept >= KIND_POS)
            begin
                if (type_flags[0])
                    r.kind = KIND_RMC;
                else if (type_flags[1])
                    r.kind = KIND_GGA;
            end
            if (!dollar_first || !star_seen)
                r.status = STAT_PARSE_ERR;
            else if (xor_acc != sum_field)
                r.status = STAT_SUM_ERR;
            else if (commas == 0)
                r.status = STAT_PARSE_ERR;
            else if (r.kind != KIND_OTHER && commas < COMMA_MAX)
                r.status = STAT_PARSE_ERR;
            else
                r.status = STAT_OK;
            r.computed_sum  = xor_acc;
            r.received_sum  = sum_field;
            r.stored_length = (kept > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(kept);
            sentence_reports.push_back(r);
            clear_sentence();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sentence();
            sentence_reports.delete();
            mismatches = 0;
            reports_pending <= 0;
        end
        else
        begin
            // a result leaves only after its newline has passed the input and result
            // registers, so the report queue is popped before this edge's byte is folded in
            if (m_tvalid && m_tready)
            begin
                if (sentence_reports.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("mismatch: report with none pending, tuser %0d tdata %h",
                                 m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = sentence_reports.pop_front();
                    if (m_tuser !== want.kind || m_tdata[1:0] !== want.status ||
                        m_tdata[9:2] !== want.computed_sum ||
                        m_tdata[17:10] !== want.received_sum ||
                        m_tdata[24:18] !== want.stored_length || m_tdata[31:25] !== '0)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch: kind/status/xor/hex/len/pad exp ",
                                      "%0d/%0d/%h/%h/%0d/0 got %0d/%0d/%h/%h/%0d/%h"},
                                     want.kind, want.status, want.computed_sum,
                                     want.received_sum, want.stored_length,
                                     m_tuser, m_tdata[1:0], m_tdata[9:2],
                                     m_tdata[17:10], m_tdata[24:18], m_tdata[31:25]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_byte(s_tdata);
            reports_pending <= sentence_reports.size();
        end
    end

endmodule

// ----- verif/nmea_sentence_checker_test.sv -----
// Testbench top for the NMEA sentence checker: clock, reset, byte stimulus,
// result back-pressure and verdict. Depends on nsc_pkg, the block and nsc_stream_checker.
module nmea_sentence_checker_test;
    import nsc_pkg::*;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_SUM,
        FLAW_NO_STAR,
        FLAW_NO_DOLLAR,
        FLAW_TRUNCATED,
        FLAW_NUL
    } flaw_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_SPARSE,
        RDY_COIN,
        RDY_BURSTY
    } ready_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int mismatches;
    int reports_pending;

    int burst_left = 0;
    int bytes_sent = 0;
    int lines_sent = 0;
    logic [7:0] body_q[$];   // text between '$' and '*'

    ready_mode_t ready_mode = RDY_ALWAYS;
    int          mode_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    nmea_sentence_checker DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    nsc_stream_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .reports_pending (reports_pending)
    );

    // Result side: a stall pattern that changes mode now and then, from
    // always ready to long stalls.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (ready_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            default:    m_tready <= (mode_left % 24) < 4;
        endcase
    end

    // One byte request. Bursts of random length, random gaps between them;
    // now and then a long burst gives a stretch with no idling.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        bytes_sent++;
        if (b == CH_NEWLINE)
            lines_sent++;
    endtask

    task automatic send_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // Hold the stream until every report has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (reports_pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 10)
            return 8'h30 + 8'(n);
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    // Sends body_q as a sentence with its checksum, spoiled as the flaw says.
    task automatic send_framed(input flaw_t flaw);
        logic [7:0] sum;
        bit         lower;
        sum = '0;
        foreach (body_q[i])
            sum = sum ^ body_q[i];
        if (flaw == FLAW_BAD_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        lower = 1'($urandom_range(0, 1));
        if (flaw != FLAW_NO_DOLLAR)
            push_byte(CH_DOLLAR);
        foreach (body_q[i])
            push_byte(body_q[i]);
        if (flaw == FLAW_TRUNCATED)
            return;
        if (flaw != FLAW_NO_STAR)
        begin
            push_byte(CH_STAR);
            push_byte(hex_char(sum[7:4], lower));
            push_byte(hex_char(sum[3:0], lower));
        end
        if ($urandom_range(0, 1))
            push_byte(8'h0D);
        push_byte(CH_NEWLINE);
    endtask

    task automatic framed(input string s, input flaw_t flaw);
        int i;
        body_q.delete();
        for (i = 0; i < s.len(); i++)
            body_q.push_back(s[i]);
        send_framed(flaw);
    endtask

    // Mostly well-formed sentences with random fields; type letters drawn from
    // a small set so near misses of RMC and GGA are common.
    task automatic random_sentence(input int max_field);
        string      tags;
        flaw_t      flaw;
        int         nfields;
        logic [7:0] ch;
        tags = "ACGMRX";
        flaw = ($urandom_range(0, 3) != 0) ? FLAW_NONE : flaw_t'($urandom_range(1, 5));
        body_q.delete();
        body_q.push_back("G");
        body_q.push_back($urandom_range(0, 1) ? "P" : "N");
        case ($urandom_range(0, 3))
            0:
            begin
                body_q.push_back("R");
                body_q.push_back("M");
                body_q.push_back("C");
            end
            1:
            begin
                body_q.push_back("G");
                body_q.push_back("G");
                body_q.push_back("A");
            end
            default:
                repeat (3) body_q.push_back(tags[$urandom_range(0, 5)]);
        endcase
        nfields = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 14);
        repeat (nfields)
        begin
            body_q.push_back(CH_COMMA);
            repeat ($urandom_range(0, max_field))
            begin
                do
                    ch = 8'($urandom_range(32, 126));
                while (ch == CH_DOLLAR || ch == CH_STAR);
                body_q.push_back(ch);
            end
        end
        if (flaw == FLAW_NUL)
            body_q.insert($urandom_range(0, body_q.size()), CH_NUL);
        send_framed(flaw);
    endtask

    initial
    begin
        int pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        send_str("\n");                                         // newline, no sentence
        framed("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W",
               FLAW_NONE);
        framed("GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,",
               FLAW_NONE);
        framed("GPGSV,3,1,11", FLAW_NONE);                      // other type, ok
        framed("GPRMC,1,2", FLAW_NONE);                         // RMC, too few commas
        framed("GPGLL,4916.45,N", FLAW_BAD_SUM);
        framed("GPVTG,054.7,T", FLAW_NO_STAR);
        framed("GPZDA,1,2", FLAW_NO_DOLLAR);
        framed("GPTXT", FLAW_NONE);                             // no comma at all
        send_str("$GPAAA,1*G1\n");                              // non-hex digit
        send_str("$GPX,*\n");                                   // star, digits absent
        send_str("$GP");                                        // NUL before type
        push_byte(CH_NUL);
        send_str("RMC,1,2,3*41\n");
        send_str("$GPQ,1*");                                    // digits past text end
        push_byte(CH_NUL);
        send_str("7F\n");
        send_str("$GP");                                        // top bit bytes
        push_byte(8'hFF);
        push_byte(8'h80);
        send_str(",x*00\n");
        send_str("$GPA,B*1*2\n");                               // second star
        body_q.delete();                                        // overflows the buffer
        send_str("");
        framed("GPRMC,", FLAW_TRUNCATED);
        repeat (140) push_byte("x");
        send_str("*00\n");
        repeat (130) push_byte("A");                            // full, then '$' restarts
        framed("GPGGA,1,2,3,4,5,6,7,8,9", FLAW_NONE);
        drain();

        // --- random part ---
        while (bytes_sent < 1900 || lines_sent < 48)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                random_sentence((pick < 3) ? 20 : 6);
            else if (pick < 96)
            begin
                repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                    push_byte(CH_NEWLINE);
            end
            else
                drain();
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && reports_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule
